@@ hdl/ogbvu_pkg.sv @@
// Shared types and constants for the occupancy grid bump and visit update core.
// Holds the controller/datapath command and status structs and the register map.
// Used by ogbvu_ctrl, ogbvu_datapath and the top level.
package ogbvu_pkg;

   // Field widths fixed by the interface.
   localparam int POS_W    = 16;
   localparam int TIME_W   = 32;
   localparam int CELL_O_W = 7;
   localparam int COUNT_W  = 4;

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_VISIT_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COUNTER_LIMIT   = 1'd1;

   localparam logic [TIME_W-1:0]  THRESHOLD_RESET = 32'd20000;
   localparam logic [COUNT_W-1:0] LIMIT_RESET     = 4'd15;

   // Stream payload widths.
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;

   typedef struct packed {
      logic accept;
      logic read;
      logic update;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

@@ hdl/ogbvu_ctrl.sv @@
// Controller for the occupancy grid core: clearing pass, read and update sequencing.
// Drives the stream handshakes and issues commands to ogbvu_datapath.
// Depends on ogbvu_pkg.
module ogbvu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ogbvu_pkg::status_type status,
   output ogbvu_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      update_go;
   logic      accept;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      update_go  = (state_ff == ST_UPDATE) && out_free;
      req_tready = (state_ff == ST_IDLE) || update_go;
      accept     = req_tvalid && req_tready;

      cmd.accept     = accept;
      cmd.read       = (state_ff == ST_READ);
      cmd.update     = update_go;
      cmd.clear_step = (state_ff == ST_CLEAR);

      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (update_go) begin
               state_in = accept ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (update_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ hdl/ogbvu_datapath.sv @@
// Datapath for the occupancy grid core: origin, cell index, counter and stamp memories.
// Performs the read-modify-write of both cell memories and holds the result register.
// Depends on ogbvu_pkg; sequenced by ogbvu_ctrl.
module ogbvu_datapath #(
   parameter int HALF_SPAN  = 40,
   parameter int STAMP_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ogbvu_pkg::cmd_type                    cmd,
   output ogbvu_pkg::status_type                 status,
   input  logic [ogbvu_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [ogbvu_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic [ogbvu_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [ogbvu_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                  csr_we,
   input  logic [ogbvu_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ogbvu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int GRID_SIDE  = 2 * HALF_SPAN + 1;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = $clog2(GRID_CELLS);
   localparam int CELL_W     = $clog2(GRID_SIDE);
   localparam int OFF_W      = ogbvu_pkg::POS_W + 2;
   localparam int SUM_W      = ((STAMP_BITS > ogbvu_pkg::TIME_W) ?
                                STAMP_BITS : ogbvu_pkg::TIME_W) + 1;
   localparam int POS_W      = ogbvu_pkg::POS_W;
   localparam int TIME_W     = ogbvu_pkg::TIME_W;
   localparam int COUNT_W    = ogbvu_pkg::COUNT_W;
   localparam int CO_W       = ogbvu_pkg::CELL_O_W;

   localparam logic signed [OFF_W-1:0] SPAN_OFF = OFF_W'(HALF_SPAN);
   localparam logic signed [OFF_W-1:0] SPAN_MAX = OFF_W'(2 * HALF_SPAN);
   localparam logic [ADDR_W-1:0]       SIDE_A   = ADDR_W'(GRID_SIDE);
   localparam logic [ADDR_W-1:0]       LAST_A   = ADDR_W'(GRID_CELLS - 1);

   // Configuration registers.
   logic [TIME_W-1:0]  threshold_ff;
   logic [COUNT_W-1:0] limit_ff;

   // Accepted item and origin.
   logic [POS_W-1:0]  px_ff, py_ff, ox_ff, oy_ff;
   logic              bump_ff;
   logic [TIME_W-1:0] now_ff;
   logic              taken_ff;

   // Cell registers from the read cycle.
   logic [CO_W-1:0]   cx_ff, cy_ff;
   logic              oor_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [COUNT_W-1:0]    cnt_rd_ff;
   logic [STAMP_BITS-1:0] stamp_rd_ff;

   // Clearing pass.
   logic [ADDR_W-1:0] clr_addr_ff;

   // Result register.
   logic [CO_W-1:0]    res_cx_ff, res_cy_ff;
   logic [COUNT_W-1:0] res_cnt_ff;
   logic               res_bump_ff, res_vis_ff, res_oor_ff;

   // Memories.
   logic [COUNT_W-1:0]    cnt_mem   [GRID_CELLS];
   logic [STAMP_BITS-1:0] stamp_mem [GRID_CELLS];

   logic signed [OFF_W-1:0] off_x, off_y;
   logic                    in_range;
   logic [ADDR_W-1:0]       idx;
   logic [ADDR_W-1:0]       rd_addr;
   logic [COUNT_W-1:0]      cnt_new;
   logic [STAMP_BITS-1:0]   now_stamp;
   logic [STAMP_BITS-1:0]   stamp_base;
   logic [STAMP_BITS-1:0]   stamp_new;
   logic [SUM_W-1:0]        stamp_sum;
   logic                    vis;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [COUNT_W-1:0]      wr_cnt;
   logic [STAMP_BITS-1:0]   wr_stamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ogbvu_pkg::THRESHOLD_RESET;
         limit_ff     <= ogbvu_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ogbvu_pkg::REG_VISIT_THRESHOLD: threshold_ff <= csr_wdata[TIME_W-1:0];
            ogbvu_pkg::REG_COUNTER_LIMIT:   limit_ff     <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= 1'b0;
         ox_ff    <= '0;
         oy_ff    <= '0;
      end else if (cmd.accept && !taken_ff) begin
         taken_ff <= 1'b1;
         ox_ff    <= req_tdata[POS_W-1:0];
         oy_ff    <= req_tdata[2*POS_W-1:POS_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff   <= req_tdata[POS_W-1:0];
         py_ff   <= req_tdata[2*POS_W-1:POS_W];
         now_ff  <= req_tdata[2*POS_W+TIME_W-1:2*POS_W];
         bump_ff <= req_tuser[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   assign status.clear_last = cmd.clear_step && (clr_addr_ff == LAST_A);

   always_comb begin
      off_x = $signed({{2{px_ff[POS_W-1]}}, px_ff})
            - $signed({{2{ox_ff[POS_W-1]}}, ox_ff}) + SPAN_OFF;
      off_y = $signed({{2{py_ff[POS_W-1]}}, py_ff})
            - $signed({{2{oy_ff[POS_W-1]}}, oy_ff}) + SPAN_OFF;
      in_range = !off_x[OFF_W-1] && (off_x <= SPAN_MAX)
              && !off_y[OFF_W-1] && (off_y <= SPAN_MAX);
      idx = ADDR_W'(off_x[CELL_W-1:0]) * SIDE_A + ADDR_W'(off_y[CELL_W-1:0]);
      rd_addr = in_range ? idx : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         cx_ff       <= off_x[CO_W-1:0];
         cy_ff       <= off_y[CO_W-1:0];
         oor_ff      <= !in_range;
         addr_ff     <= rd_addr;
         cnt_rd_ff   <= cnt_mem[rd_addr];
         stamp_rd_ff <= stamp_mem[rd_addr];
      end
   end

   always_comb begin
      cnt_new = cnt_rd_ff;
      if (bump_ff) begin
         if (cnt_rd_ff < limit_ff) begin
            cnt_new = cnt_rd_ff + COUNT_W'(1);
         end
      end else if (cnt_rd_ff != '0) begin
         cnt_new = cnt_rd_ff - COUNT_W'(1);
      end

      now_stamp  = STAMP_BITS'(SUM_W'(now_ff));
      stamp_base = (stamp_rd_ff == '0) ? now_stamp : stamp_rd_ff;
      stamp_sum  = SUM_W'(stamp_base) + SUM_W'(threshold_ff);
      vis        = (SUM_W'(now_ff) >= stamp_sum);
      stamp_new  = vis ? stamp_base : now_stamp;

      wr_en    = cmd.clear_step || (cmd.update && !oor_ff);
      wr_addr  = cmd.clear_step ? clr_addr_ff : addr_ff;
      wr_cnt   = cmd.clear_step ? '0 : cnt_new;
      wr_stamp = cmd.clear_step ? '0 : stamp_new;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_addr]   <= wr_cnt;
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_bump_ff <= bump_ff;
         res_oor_ff  <= oor_ff;
         if (oor_ff) begin
            res_cx_ff  <= '0;
            res_cy_ff  <= '0;
            res_cnt_ff <= '0;
            res_vis_ff <= 1'b0;
         end else begin
            res_cx_ff  <= cx_ff;
            res_cy_ff  <= cy_ff;
            res_cnt_ff <= cnt_new;
            res_vis_ff <= vis;
         end
      end
   end

   assign rsp_tdata = {{(ogbvu_pkg::RSP_DATA_W - 2*CO_W - COUNT_W){1'b0}},
                       res_cnt_ff, res_cy_ff, res_cx_ff};
   assign rsp_tuser = {res_oor_ff, res_vis_ff, res_bump_ff};

endmodule

@@ hdl/occupancy_grid_bump_visit_update_core.sv @@
// Occupancy grid core: per-cell saturating bump counters and visit stamps.
// The result is registered once the cell memories are read (READ) and written (UPDATE);
// the write waits while a result is still held, and the next item is accepted with it.
// Reset is synchronous; afterwards a clearing pass over all (2*HALF_SPAN+1)**2 cells
// (6561 by default) zeroes both memories before the first item is accepted.
module occupancy_grid_bump_visit_update_core #(
   parameter int HALF_SPAN  = 40,
   parameter int STAMP_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_x_dm[15:0], pos_y_dm[31:16], now_ms[63:32]
   input  logic [ogbvu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // bump[0]
   input  logic [ogbvu_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // cell_x[6:0], cell_y[13:7], cell_count[17:14], zero fill[23:18]
   output logic [ogbvu_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // bump_echo[0], visited[1], out_of_range[2]
   output logic [ogbvu_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                  csr_we,
   input  logic [ogbvu_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ogbvu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ogbvu_pkg::cmd_type    cmd;
   ogbvu_pkg::status_type status;

   ogbvu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ogbvu_datapath #(
      .HALF_SPAN  (HALF_SPAN),
      .STAMP_BITS (STAMP_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ bench/occupancy_grid_bump_visit_update_core_tb.sv @@
// Self-checking bench for occupancy_grid_bump_visit_update_core: drives odometry transfers,
// predicts each cell report from its own grid tables and compares every report transfer.
// Depends on ogbvu_pkg and the core RTL only.
`timescale 1ns / 100ps

module occupancy_grid_bump_visit_update_core_tb;

   localparam int HALF_SPAN    = 40;
   localparam int GRID_SIDE    = 2 * HALF_SPAN + 1;
   localparam int GRID_CELLS   = GRID_SIDE * GRID_SIDE;
   localparam int ORIGIN_X     = -1234;
   localparam int ORIGIN_Y     = 777;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 240;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [ogbvu_pkg::POS_W-1:0] pos_x;
      logic signed [ogbvu_pkg::POS_W-1:0] pos_y;
      logic                               bump;
      logic [ogbvu_pkg::TIME_W-1:0]       now_ms;
   } odometry_type;

   typedef struct {
      logic [ogbvu_pkg::CELL_O_W-1:0] cell_x;
      logic [ogbvu_pkg::CELL_O_W-1:0] cell_y;
      logic                           bump_echo;
      logic [ogbvu_pkg::COUNT_W-1:0]  cell_count;
      logic                           visited;
      logic                           out_of_range;
   } cell_report_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [ogbvu_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [ogbvu_pkg::REQ_USER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [ogbvu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [ogbvu_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic csr_we;
   logic [ogbvu_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [ogbvu_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Predicted grid state and register copies.
   logic [ogbvu_pkg::TIME_W-1:0]  visit_threshold;
   logic [ogbvu_pkg::COUNT_W-1:0] counter_limit;
   int                            origin_x;
   int                            origin_y;
   logic                          origin_taken;
   logic [ogbvu_pkg::COUNT_W-1:0] bump_counts [GRID_CELLS];
   logic [ogbvu_pkg::TIME_W-1:0]  visit_stamps [GRID_CELLS];

   odometry_type    odometry_queue [$];
   cell_report_type reports_due [$];
   odometry_type    on_bus;
   int              send_gap;
   int              rsp_stall;
   int              results_seen;
   int              error_count;
   bit              idling_on;
   logic [ogbvu_pkg::TIME_W-1:0] time_ms;
   int unsigned     cycle_count;

   occupancy_grid_bump_visit_update_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic cell_report_type update_cell_tables(odometry_type o);
      cell_report_type r;
      int cx;
      int cy;
      int idx;
      logic [ogbvu_pkg::COUNT_W-1:0] cnt;
      logic [ogbvu_pkg::TIME_W-1:0] stamp;
      r = '{default: '0};
      r.bump_echo = o.bump;
      if (!origin_taken) begin
         origin_x = int'(o.pos_x);
         origin_y = int'(o.pos_y);
         origin_taken = 1'b1;
      end
      cx = int'(o.pos_x) - origin_x + HALF_SPAN;
      cy = int'(o.pos_y) - origin_y + HALF_SPAN;
      if (cx < 0 || cx >= GRID_SIDE || cy < 0 || cy >= GRID_SIDE) begin
         r.out_of_range = 1'b1;
         return r;
      end
      idx = cx * GRID_SIDE + cy;
      cnt = bump_counts[idx];
      if (o.bump) begin
         if (cnt < counter_limit) cnt = cnt + 1'b1;
      end else if (cnt != 0) begin
         cnt = cnt - 1'b1;
      end
      bump_counts[idx] = cnt;
      // A stamp of zero means the cell was never seen; the sum is compared without wrap.
      stamp = visit_stamps[idx];
      if (stamp == 0) stamp = o.now_ms;
      if (stamp <= o.now_ms && o.now_ms - stamp >= visit_threshold) begin
         r.visited = 1'b1;
      end else begin
         stamp = o.now_ms;
      end
      visit_stamps[idx] = stamp;
      r.cell_x = cx[ogbvu_pkg::CELL_O_W-1:0];
      r.cell_y = cy[ogbvu_pkg::CELL_O_W-1:0];
      r.cell_count = cnt;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("report %0d %s got %0h expected %0h",
                                   results_seen, name, got, want));
   endtask

   task automatic push_abs(input int px, input int py, input logic bump,
                           input logic [ogbvu_pkg::TIME_W-1:0] now);
      odometry_type o;
      o.pos_x = ogbvu_pkg::POS_W'(px);
      o.pos_y = ogbvu_pkg::POS_W'(py);
      o.bump = bump;
      o.now_ms = now;
      odometry_queue.push_back(o);
   endtask

   task automatic push_rel(input int dx, input int dy, input logic bump,
                           input logic [ogbvu_pkg::TIME_W-1:0] now);
      push_abs(ORIGIN_X + dx, ORIGIN_Y + dy, bump, now);
   endtask

   task automatic write_reg(input logic [ogbvu_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [ogbvu_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [ogbvu_pkg::TIME_W-1:0] threshold,
                             input logic [ogbvu_pkg::COUNT_W-1:0] limit);
      write_reg(ogbvu_pkg::REG_VISIT_THRESHOLD, threshold);
      write_reg(ogbvu_pkg::REG_COUNTER_LIMIT, ogbvu_pkg::CSR_DATA_W'(limit));
      visit_threshold = threshold;
      counter_limit = limit;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (odometry_queue.size() != 0 || req_tvalid || reports_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_phase(input int n);
      int sel;
      int dx;
      int dy;
      for (int k = 0; k < n; k++) begin
         time_ms = time_ms + $urandom_range(0, 300);
         sel = $urandom_range(0, 99);
         dx = int'($urandom_range(0, 80)) - HALF_SPAN;
         dy = int'($urandom_range(0, 80)) - HALF_SPAN;
         if (sel < 70) begin
            // A small window around the origin keeps revisiting the same cells.
            dx = int'($urandom_range(0, 6)) - 3;
            dy = int'($urandom_range(0, 6)) - 3;
         end else if (sel >= 93) begin
            if ($urandom_range(0, 1)) dx = ($urandom_range(0, 1) ? 1 : -1) *
                                           int'($urandom_range(HALF_SPAN, HALF_SPAN + 20));
            else dy = ($urandom_range(0, 1) ? 1 : -1) *
                      int'($urandom_range(HALF_SPAN, HALF_SPAN + 20));
         end
         if (sel >= 85 && sel < 93)
            push_abs($urandom(), $urandom(), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom() : time_ms);
         else
            push_rel(dx, dy, 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom() : time_ms);
      end
      wait_drained();
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            reports_due.push_back(update_cell_tables(on_bus));
            if (idling_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 17);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (odometry_queue.size() != 0) begin
               on_bus = odometry_queue.pop_front();
               req_tdata <= {on_bus.now_ms, on_bus.pos_y, on_bus.pos_x};
               req_tuser <= on_bus.bump;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      cell_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (reports_due.size() == 0) begin
               report_mismatch($sformatf("report %0d arrived with no odometry pending",
                                         results_seen));
            end else begin
               want = reports_due.pop_front();
               compare_field("cell_x", 32'(rsp_tdata[6:0]), 32'(want.cell_x));
               compare_field("cell_y", 32'(rsp_tdata[13:7]), 32'(want.cell_y));
               compare_field("cell_count", 32'(rsp_tdata[17:14]), 32'(want.cell_count));
               compare_field("bump_echo", 32'(rsp_tuser[0]), 32'(want.bump_echo));
               compare_field("visited", 32'(rsp_tuser[1]), 32'(want.visited));
               compare_field("out_of_range", 32'(rsp_tuser[2]), 32'(want.out_of_range));
            end
            // One long hold-off lets the core back up and stall its input side.
            if (results_seen == HOLD_AT) rsp_stall = HOLD_CYCLES;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 17);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      idling_on = 1'b1;
      results_seen = 0;
      error_count = 0;
      time_ms = 32'd5000;
      visit_threshold = ogbvu_pkg::THRESHOLD_RESET;
      counter_limit = ogbvu_pkg::LIMIT_RESET;
      origin_x = 0;
      origin_y = 0;
      origin_taken = 1'b0;
      foreach (bump_counts[i]) bump_counts[i] = '0;
      foreach (visit_stamps[i]) visit_stamps[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset register values. The first transfer sets the origin; a stamp written
      // at time zero still reads as never seen.
      push_rel(0, 0, 1'b1, 32'd0);
      push_rel(0, 0, 1'b1, 32'd100);
      push_rel(0, 0, 1'b0, 32'd20100);
      push_rel(0, 0, 1'b0, 32'd50);
      push_rel(-HALF_SPAN, -HALF_SPAN, 1'b1, 32'hFFFF_FFFF);
      push_rel(HALF_SPAN, HALF_SPAN, 1'b1, 32'd1);
      push_rel(HALF_SPAN + 1, 0, 1'b1, 32'd7);
      push_rel(0, -HALF_SPAN - 1, 1'b0, 32'd8);
      push_abs(32767, -32768, 1'b1, 32'd9);
      push_abs(-32768, 32767, 1'b0, 32'd10);
      push_rel(5, 5, 1'b1, 32'd1000);
      push_rel(5, 5, 1'b1, 32'd1001);
      push_rel(5, 5, 1'b1, 32'd1002);
      wait_drained();

      // Limit below a stored count, and a threshold sum that would wrap.
      set_config(32'hFFFF_FFFF, 4'd2);
      push_rel(5, 5, 1'b1, 32'd3000);
      push_rel(5, 5, 1'b0, 32'd3001);
      push_rel(5, 5, 1'b1, 32'd3002);
      push_rel(HALF_SPAN, HALF_SPAN, 1'b0, 32'hFFFF_FFFF);
      push_rel(-HALF_SPAN, HALF_SPAN, 1'b1, 32'd4000);
      wait_drained();

      // A zero limit never raises a counter; a zero threshold visits at once.
      set_config(32'd0, 4'd0);
      push_rel(2, -3, 1'b1, 32'd10);
      push_rel(5, 5, 1'b1, 32'd3100);
      push_rel(HALF_SPAN, -HALF_SPAN, 1'b0, 32'd3200);
      wait_drained();

      set_config($urandom_range(1000, 15000), 4'd15);
      run_random_phase(95);
      set_config(32'd0, 4'd1);
      run_random_phase(95);
      set_config(32'hFFFF_FFFF, ogbvu_pkg::COUNT_W'($urandom_range(1, 14)));
      run_random_phase(95);
      idling_on = 1'b0;
      set_config($urandom_range(1, 400), ogbvu_pkg::COUNT_W'($urandom_range(3, 15)));
      run_random_phase(95);

      repeat (8) @(posedge clock);
      if (error_count == 0 && reports_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
